>>> src/ctbg_pkg.sv
// Shared types, register indexes and reset values for the coded tone burst generator.
package ctbg_pkg;

  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 24;
  localparam int DEFAULT_TIMER_WIDTH = 24;

  localparam int HALF_W   = 8;
  localparam int PHASE_W  = 16;
  localparam int COUNT_W  = 4;
  localparam int SINCE_W  = 20;
  localparam int PERIOD_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REARM        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd6;

  localparam logic [HALF_W-1:0]   RST_HALF_PERIOD  = 8'd12;
  localparam logic [PHASE_W-1:0]  RST_BURST_LENGTH = 16'd15000;
  localparam logic [COUNT_W-1:0]  RST_BURST_COUNT  = 4'd3;
  localparam logic [PHASE_W-1:0]  RST_GAP          = 16'd10000;
  localparam logic [SINCE_W-1:0]  RST_REARM        = 20'd100000;
  localparam logic [PERIOD_W-1:0] RST_AUTO_PERIOD  = 24'd5000000;
  localparam logic [PERIOD_W-1:0] RST_BLINK_PERIOD = 24'd1000000;

  typedef struct packed {
    logic [HALF_W-1:0]   half_period;
    logic [PHASE_W-1:0]  burst_length;
    logic [COUNT_W-1:0]  burst_count;
    logic [PHASE_W-1:0]  gap;
    logic [SINCE_W-1:0]  rearm;
    logic [PERIOD_W-1:0] auto_period;
    logic [PERIOD_W-1:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic drive;
    logic led;
    logic busy;
    logic armed;
  } res_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_BURST = 3'b010,
    MODE_GAP   = 3'b100
  } mode_t;

endpackage

>>> src/ctbg_cfg_regs.sv
// Configuration register file with write port and reset defaults.
module ctbg_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ctbg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctbg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output ctbg_pkg::cfg_t                       cfg
);

  ctbg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period  <= ctbg_pkg::RST_HALF_PERIOD;
      cfg_r.burst_length <= ctbg_pkg::RST_BURST_LENGTH;
      cfg_r.burst_count  <= ctbg_pkg::RST_BURST_COUNT;
      cfg_r.gap          <= ctbg_pkg::RST_GAP;
      cfg_r.rearm        <= ctbg_pkg::RST_REARM;
      cfg_r.auto_period  <= ctbg_pkg::RST_AUTO_PERIOD;
      cfg_r.blink_period <= ctbg_pkg::RST_BLINK_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctbg_pkg::REG_HALF_PERIOD:
          cfg_r.half_period <= cfg_wdata[ctbg_pkg::HALF_W-1:0];
        ctbg_pkg::REG_BURST_LENGTH:
          cfg_r.burst_length <= cfg_wdata[ctbg_pkg::PHASE_W-1:0];
        ctbg_pkg::REG_BURST_COUNT:
          cfg_r.burst_count <= cfg_wdata[ctbg_pkg::COUNT_W-1:0];
        ctbg_pkg::REG_GAP:
          cfg_r.gap <= cfg_wdata[ctbg_pkg::PHASE_W-1:0];
        ctbg_pkg::REG_REARM:
          cfg_r.rearm <= cfg_wdata[ctbg_pkg::SINCE_W-1:0];
        ctbg_pkg::REG_AUTO_PERIOD:
          cfg_r.auto_period <= cfg_wdata[ctbg_pkg::PERIOD_W-1:0];
        ctbg_pkg::REG_BLINK_PERIOD:
          cfg_r.blink_period <= cfg_wdata[ctbg_pkg::PERIOD_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/ctbg_core.sv
// Sequencer state, tick counters and per-tick next-state logic.
module ctbg_core #(
  parameter int TIMER_WIDTH = ctbg_pkg::DEFAULT_TIMER_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           trig,
  input  logic           test,
  input  ctbg_pkg::cfg_t cfg,
  output ctbg_pkg::res_t res_nxt
);

  localparam int CMP_W = (TIMER_WIDTH > ctbg_pkg::PERIOD_W) ? TIMER_WIDTH
                                                             : ctbg_pkg::PERIOD_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [ctbg_pkg::SINCE_W-1:0] SINCE_MAX = {ctbg_pkg::SINCE_W{1'b1}};
  localparam logic [ctbg_pkg::PHASE_W-1:0] PHASE_MAX = {ctbg_pkg::PHASE_W{1'b1}};

  ctbg_pkg::mode_t                  mode_r, mode_nxt;
  logic [ctbg_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [ctbg_pkg::HALF_W-1:0]      carrier_r, carrier_nxt;
  logic [ctbg_pkg::COUNT_W-1:0]     bursts_r, bursts_nxt;
  logic                             drive_r, drive_nxt;
  logic                             led_r, led_nxt;
  logic                             armed_r, armed_nxt;
  logic [ctbg_pkg::SINCE_W-1:0]     since_r, since_nxt;
  logic [TIMER_WIDTH-1:0]           auto_r, auto_nxt;
  logic [TIMER_WIDTH-1:0]           blink_r, blink_nxt;

  logic [ctbg_pkg::PHASE_W-1:0]     phase_inc;
  logic [ctbg_pkg::HALF_W-1:0]      carrier_inc;
  logic [ctbg_pkg::COUNT_W-1:0]     bursts_inc;
  logic [ctbg_pkg::COUNT_W-1:0]     need;
  logic                             start_seq;

  always_comb begin
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    carrier_nxt = carrier_r;
    bursts_nxt  = bursts_r;
    drive_nxt   = drive_r;
    led_nxt     = led_r;
    armed_nxt   = armed_r;
    since_nxt   = (since_r == SINCE_MAX) ? since_r : since_r + 1'b1;
    auto_nxt    = (auto_r == TIMER_MAX) ? auto_r : auto_r + 1'b1;
    blink_nxt   = (blink_r == TIMER_MAX) ? blink_r : blink_r + 1'b1;
    phase_inc   = (phase_r == PHASE_MAX) ? phase_r : phase_r + 1'b1;
    carrier_inc = carrier_r + 1'b1;
    bursts_inc  = bursts_r + 1'b1;
    need        = (cfg.burst_count == '0) ? ctbg_pkg::COUNT_W'(1) : cfg.burst_count;
    start_seq   = 1'b0;

    unique case (mode_r)
      ctbg_pkg::MODE_GAP: begin
        phase_nxt = phase_inc;
        if (phase_inc >= cfg.gap) begin
          mode_nxt    = ctbg_pkg::MODE_BURST;
          phase_nxt   = '0;
          carrier_nxt = '0;
          drive_nxt   = 1'b1;
        end
      end
      ctbg_pkg::MODE_BURST: begin
        phase_nxt   = phase_inc;
        carrier_nxt = carrier_inc;
        if (carrier_inc >= cfg.half_period) begin
          carrier_nxt = '0;
          if (drive_r) begin
            drive_nxt = 1'b0;
          end else if (phase_inc < cfg.burst_length) begin
            drive_nxt = 1'b1;
          end else begin
            // burst time spent at the end of a low half: close the burst
            drive_nxt  = 1'b0;
            bursts_nxt = bursts_inc;
            phase_nxt  = '0;
            if (bursts_inc >= need) begin
              mode_nxt   = ctbg_pkg::MODE_IDLE;
              led_nxt    = 1'b0;
              bursts_nxt = '0;
            end else if (cfg.gap == '0) begin
              drive_nxt = 1'b1;
            end else begin
              mode_nxt = ctbg_pkg::MODE_GAP;
            end
          end
        end
      end
      default: begin
        mode_nxt = ctbg_pkg::MODE_IDLE;
        if (trig) begin
          if (!armed_r) begin
            armed_nxt = 1'b1;
            since_nxt = '0;
            start_seq = 1'b1;
          end
        end else if (armed_r && (since_nxt > cfg.rearm)) begin
          armed_nxt = 1'b0;
        end
        if (!armed_nxt && (CMP_W'(blink_nxt) > CMP_W'(cfg.blink_period))) begin
          led_nxt   = ~led_nxt;
          blink_nxt = '0;
        end
        if (!armed_nxt && (CMP_W'(auto_nxt) > CMP_W'(cfg.auto_period))) begin
          auto_nxt  = '0;
          start_seq = 1'b1;
        end
        if (test) begin
          start_seq = 1'b1;
        end
        // a start overrides any LED toggle from this tick
        if (start_seq) begin
          mode_nxt    = ctbg_pkg::MODE_BURST;
          phase_nxt   = '0;
          carrier_nxt = '0;
          bursts_nxt  = '0;
          drive_nxt   = 1'b1;
          led_nxt     = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ctbg_pkg::MODE_IDLE;
      phase_r   <= '0;
      carrier_r <= '0;
      bursts_r  <= '0;
      drive_r   <= 1'b0;
      led_r     <= 1'b0;
      armed_r   <= 1'b0;
      since_r   <= '0;
      auto_r    <= '0;
      blink_r   <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      carrier_r <= carrier_nxt;
      bursts_r  <= bursts_nxt;
      drive_r   <= drive_nxt;
      led_r     <= led_nxt;
      armed_r   <= armed_nxt;
      since_r   <= since_nxt;
      auto_r    <= auto_nxt;
      blink_r   <= blink_nxt;
    end
  end

  assign res_nxt.drive = drive_nxt;
  assign res_nxt.led   = led_nxt;
  assign res_nxt.busy  = (mode_nxt != ctbg_pkg::MODE_IDLE);
  assign res_nxt.armed = armed_nxt;

  a_led_on_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != ctbg_pkg::MODE_IDLE) |-> led_r)
    else $error("LED low while a sequence runs");

  a_gap_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ctbg_pkg::MODE_GAP) |-> !drive_r)
    else $error("drive high during a gap");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ctbg_pkg::MODE_IDLE) |->
      (!drive_r && (phase_r == '0) && (carrier_r == '0) && (bursts_r == '0)))
    else $error("sequence state left over in idle");

  a_arm_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(armed_r) |-> ($past(step_en) && $past(trig) && $past(mode_r) == ctbg_pkg::MODE_IDLE))
    else $error("armed without a high trigger in idle");

endmodule

>>> src/coded_tone_burst_generator.sv
// Top level: configuration registers, tick sequencer and output register.
//
// Each request on the in_ channel is one timebase tick carrying the trigger
// level and a manual test request. Every accepted request yields exactly one
// result on the out_ channel: drive and LED levels, busy and armed flags as
// they stand after that tick.
// The result is registered and is valid the cycle after the request is accepted.
// Throughput: one request per cycle while out_ready holds; the next-state logic
// of the sequencer is a single registered pass over the counters and compares.
// The output register decouples the channels: in_ready is high whenever the
// output register is empty or is being taken in the same cycle, so a stalled
// receiver holds back at most one result and then stalls the sender.
// Reset (rst_n low, synchronous) loads the register defaults, idles the
// sequencer, clears all counters, drops armed and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// unmapped indexes are ignored. Write only while no request is in flight.
module coded_tone_burst_generator #(
  parameter int TIMER_WIDTH = ctbg_pkg::DEFAULT_TIMER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_trigger_level,
  input  logic                            in_test_request,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_level,
  output logic                            out_led_level,
  output logic                            out_busy_res,
  output logic                            out_armed,
  input  logic                            cfg_we,
  input  logic [ctbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctbg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ctbg_pkg::cfg_t cfg;
  ctbg_pkg::res_t res_nxt;
  ctbg_pkg::res_t res_r;
  logic           out_valid_r;
  logic           in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  ctbg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctbg_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .trig    (in_trigger_level),
    .test    (in_test_request),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_level = res_r.drive;
  assign out_led_level   = res_r.led;
  assign out_busy_res    = res_r.busy;
  assign out_armed       = res_r.armed;

endmodule

>>> tb/sv/coded_tone_burst_generator_tb.sv
// Self-checking testbench for the coded tone burst generator: directed table then random phases.
module coded_tone_burst_generator_tb;
  import ctbg_pkg::*;

  localparam int TW = DEFAULT_TIMER_WIDTH;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 14;
  localparam int TICKS_PER_PHASE = 125;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  trig;
    logic                  test;
    bit                    pinned;
    res_t                  pin;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_trigger_level = 1'b0;
  logic in_test_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic out_drive_level, out_led_level, out_busy_res, out_armed;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  coded_tone_burst_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_trigger_level (in_trigger_level),
    .in_test_request  (in_test_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_level  (out_drive_level),
    .out_led_level    (out_led_level),
    .out_busy_res     (out_busy_res),
    .out_armed        (out_armed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sequencer shadow
  cfg_t                regs;
  mode_t               seq_mode;
  logic [PHASE_W-1:0]  phase_cnt;
  logic [HALF_W-1:0]   carrier_cnt;
  logic [COUNT_W-1:0]  bursts_fired;
  logic                drive_q, led_q, armed_q;
  logic [SINCE_W-1:0]  since_cmd;
  logic [TW-1:0]       auto_cnt, blink_cnt;

  res_t awaited_levels[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void start_burst();
    seq_mode = MODE_BURST;
    phase_cnt = '0;
    carrier_cnt = '0;
    drive_q = 1'b1;
  endfunction

  function automatic void start_sequence();
    bursts_fired = '0;
    led_q = 1'b1;
    start_burst();
  endfunction

  function automatic void finish_burst();
    logic [COUNT_W-1:0] need;
    need = (regs.burst_count == '0) ? COUNT_W'(1) : regs.burst_count;
    drive_q = 1'b0;
    bursts_fired = bursts_fired + 1'b1;
    if (bursts_fired >= need) begin
      seq_mode = MODE_IDLE;
      led_q = 1'b0;
      phase_cnt = '0;
      carrier_cnt = '0;
      bursts_fired = '0;
    end else if (regs.gap == '0) begin
      start_burst();
    end else begin
      seq_mode = MODE_GAP;
      phase_cnt = '0;
      carrier_cnt = '0;
    end
  endfunction

  // Advances the shadow by one tick and returns the levels after it.
  function automatic res_t next_levels(logic trig, logic test);
    logic started;
    res_t r;
    started = 1'b0;
    if (since_cmd != '1) since_cmd = since_cmd + 1'b1;
    if (auto_cnt != '1) auto_cnt = auto_cnt + 1'b1;
    if (blink_cnt != '1) blink_cnt = blink_cnt + 1'b1;
    if (seq_mode != MODE_IDLE) begin
      if (phase_cnt != '1) phase_cnt = phase_cnt + 1'b1;
      if (seq_mode == MODE_GAP) begin
        if (phase_cnt >= regs.gap) start_burst();
      end else begin
        carrier_cnt = carrier_cnt + 1'b1;
        if (carrier_cnt >= regs.half_period) begin
          carrier_cnt = '0;
          if (drive_q) drive_q = 1'b0;
          else if (phase_cnt < regs.burst_length) drive_q = 1'b1;
          else finish_burst();
        end
      end
    end else begin
      if (trig) begin
        if (!armed_q) begin
          armed_q = 1'b1;
          since_cmd = '0;
          start_sequence();
          started = 1'b1;
        end
      end else if (armed_q && since_cmd > regs.rearm) begin
        armed_q = 1'b0;
      end
      if (!armed_q && blink_cnt > regs.blink_period) begin
        led_q = ~led_q;
        blink_cnt = '0;
      end
      if (!armed_q && auto_cnt > regs.auto_period) begin
        auto_cnt = '0;
        if (!started) begin
          start_sequence();
          started = 1'b1;
        end
      end
      if (test && !started) start_sequence();
    end
    r.drive = drive_q;
    r.led   = led_q;
    r.busy  = (seq_mode != MODE_IDLE);
    r.armed = armed_q;
    return r;
  endfunction

  function automatic step_t tick_row(logic trig, logic test);
    step_t s;
    s = '{default: '0};
    s.trig = trig;
    s.test = test;
    return s;
  endfunction

  function automatic step_t pinned_row(logic trig, logic test, res_t r);
    step_t s;
    s = tick_row(trig, test);
    s.pinned = 1'b1;
    s.pin = r;
    return s;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    step_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.idx = idx;
    s.data = d;
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_value(int unsigned small_hi,
                                                       logic [CFG_DATA_W-1:0] top);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return top;
    return CFG_DATA_W'($urandom_range(1, small_hi));
  endfunction

  function automatic void check_field(string name, logic exp_v, logic got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s: expected %b, got %b", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // All tasks below start and end on a falling edge.
  task automatic send_tick(input logic trig, input logic test, input bit pinned,
                           input res_t pin);
    res_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_trigger_level <= trig;
    in_test_request <= test;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_levels(trig, test);
    awaited_levels.push_back(pinned ? pin : predicted);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_levels.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_HALF_PERIOD:  regs.half_period  = data[HALF_W-1:0];
      REG_BURST_LENGTH: regs.burst_length = data[PHASE_W-1:0];
      REG_BURST_COUNT:  regs.burst_count  = data[COUNT_W-1:0];
      REG_GAP:          regs.gap          = data[PHASE_W-1:0];
      REG_REARM:        regs.rearm        = data[SINCE_W-1:0];
      REG_AUTO_PERIOD:  regs.auto_period  = data[PERIOD_W-1:0];
      REG_BLINK_PERIOD: regs.blink_period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    res_t got, want;
    got = {out_drive_level, out_led_level, out_busy_res, out_armed};
    if (rst_n && out_valid && out_ready) begin
      if (awaited_levels.size() == 0) begin
        $display("%0t unexpected result: expected none, got %b", $time, got);
        mismatches++;
      end else begin
        want = awaited_levels.pop_front();
        check_field("drive_level", want.drive, got.drive);
        check_field("led_level", want.led, got.led);
        check_field("busy_res", want.busy, got.busy);
        check_field("armed", want.armed, got.armed);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    step_t plan[$];
    cfg_t  c;
    logic  trig_lvl;
    int unsigned flip_pct, test_pct;

    regs = '{half_period: RST_HALF_PERIOD, burst_length: RST_BURST_LENGTH,
             burst_count: RST_BURST_COUNT, gap: RST_GAP, rearm: RST_REARM,
             auto_period: RST_AUTO_PERIOD, blink_period: RST_BLINK_PERIOD};
    seq_mode = MODE_IDLE;
    phase_cnt = '0;
    carrier_cnt = '0;
    bursts_fired = '0;
    drive_q = 1'b0;
    led_q = 1'b0;
    armed_q = 1'b0;
    since_cmd = '0;
    auto_cnt = '0;
    blink_cnt = '0;
    trig_lvl = 1'b0;

    // after reset, then a test request; a request while busy is dropped
    plan.push_back(pinned_row(1'b0, 1'b0, 4'b0000));
    plan.push_back(pinned_row(1'b0, 1'b0, 4'b0000));
    plan.push_back(pinned_row(1'b0, 1'b1, 4'b1110));
    plan.push_back(tick_row(1'b1, 1'b1));
    // zero half period, unit burst, zero count and zero gap, mid-sequence
    plan.push_back(reg_row(REG_HALF_PERIOD, '0));
    plan.push_back(reg_row(REG_BURST_LENGTH, 24'd1));
    plan.push_back(reg_row(REG_BURST_COUNT, '0));
    plan.push_back(reg_row(REG_GAP, '0));
    repeat (3) plan.push_back(tick_row(1'b0, 1'b0));
    // trigger arms; two bursts back to back through the zero gap
    plan.push_back(reg_row(REG_BURST_COUNT, 24'd2));
    plan.push_back(pinned_row(1'b1, 1'b0, 4'b1111));
    repeat (5) plan.push_back(tick_row(1'b0, 1'b0));
    // low trigger disarms straight away
    plan.push_back(reg_row(REG_REARM, '0));
    plan.push_back(tick_row(1'b0, 1'b0));
    // blink and auto both fire on the first idle tick
    plan.push_back(reg_row(REG_BLINK_PERIOD, '0));
    plan.push_back(reg_row(REG_AUTO_PERIOD, 24'd1));
    repeat (5) plan.push_back(tick_row(1'b0, 1'b0));
    // unmapped index, then every register at its top value
    plan.push_back(reg_row(REG_UNMAPPED, '1));
    plan.push_back(reg_row(REG_HALF_PERIOD, 24'hFF));
    plan.push_back(reg_row(REG_BURST_LENGTH, 24'hFFFF));
    plan.push_back(reg_row(REG_BURST_COUNT, 24'hF));
    plan.push_back(reg_row(REG_GAP, 24'hFFFF));
    plan.push_back(reg_row(REG_REARM, 24'hFFFFF));
    plan.push_back(reg_row(REG_AUTO_PERIOD, 24'hFFFFFF));
    plan.push_back(reg_row(REG_BLINK_PERIOD, 24'hFFFFFF));
    plan.push_back(pinned_row(1'b1, 1'b1, 4'b1111));
    plan.push_back(tick_row(1'b0, 1'b1));
    plan.push_back(tick_row(1'b1, 1'b0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].trig, plan[i].test, plan[i].pinned, plan[i].pin);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      c.half_period  = HALF_W'(draw_value(4, 24'hFF));
      c.burst_length = PHASE_W'(draw_value(40, 24'hFFFF));
      c.burst_count  = COUNT_W'(draw_value(4, 24'hF));
      c.gap          = PHASE_W'(draw_value(25, 24'hFFFF));
      c.rearm        = SINCE_W'(draw_value(80, 24'hFFFFF));
      c.auto_period  = PERIOD_W'(draw_value(200, 24'hFFFFFF));
      c.blink_period = PERIOD_W'(draw_value(60, 24'hFFFFFF));
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
      write_reg(REG_HALF_PERIOD, CFG_DATA_W'(c.half_period));
      write_reg(REG_BURST_LENGTH, CFG_DATA_W'(c.burst_length));
      write_reg(REG_BURST_COUNT, CFG_DATA_W'(c.burst_count));
      write_reg(REG_GAP, CFG_DATA_W'(c.gap));
      write_reg(REG_REARM, CFG_DATA_W'(c.rearm));
      write_reg(REG_AUTO_PERIOD, CFG_DATA_W'(c.auto_period));
      write_reg(REG_BLINK_PERIOD, CFG_DATA_W'(c.blink_period));
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // held trigger levels mostly; every third phase is a noisy line
      flip_pct = (p % 3 == 2) ? 50 : 6;
      test_pct = (p % 3 == 1) ? 2 : 8;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < flip_pct) trig_lvl = ~trig_lvl;
        send_tick(trig_lvl, $urandom_range(0, 99) < test_pct, 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && awaited_levels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (awaited_levels.size() != 0)
        $display("%0t %0d results never arrived", $time, awaited_levels.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ctbg_pkg.sv
src/ctbg_cfg_regs.sv
src/ctbg_core.sv
src/coded_tone_burst_generator.sv
tb/sv/coded_tone_burst_generator_tb.sv
